FILE: rtl/fhc_pkg.sv
`timescale 1ns / 1ps
package fhc_pkg;

  // Field widths
  localparam int unsigned LvlW   = 3;
  localparam int unsigned TempW  = 19;
  localparam int unsigned CalcW  = 20;
  localparam int unsigned TripW  = 18;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef logic [LvlW-1:0]  lvl_t;
  typedef logic [TripW-1:0] trip_mc_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_POLICY_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIXED_LEVEL    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_ONE_C     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_TWO_C     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_THREE_C   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TRIP_FOUR_C    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OVERRIDE_LEVEL = 3'd6;

  // Policy modes
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_FIXED  = 2'd1;
  localparam logic [1:0] MODE_CUSTOM = 2'd2;

  localparam lvl_t LVL_SAFE = 3'd2;
  localparam lvl_t LVL_MAX  = 3'd4;

  // Default trips in milli-C for levels 1..4
  localparam trip_mc_t DEF_TRIP_1 = 18'd50000;
  localparam trip_mc_t DEF_TRIP_2 = 18'd60000;
  localparam trip_mc_t DEF_TRIP_3 = 18'd67500;
  localparam trip_mc_t DEF_TRIP_4 = 18'd75000;

  localparam logic [7:0] CUSTOM_MIN_C = 8'd30;
  localparam logic [7:0] CUSTOM_MAX_C = 8'd90;
  localparam logic [9:0] MILLI_PER_C  = 10'd1000;

  localparam logic signed [CalcW-1:0] HYST_MC  = 20'sd5000;
  localparam logic signed [CalcW-1:0] TEMP_MIN = -20'sd50000;
  localparam logic signed [CalcW-1:0] TEMP_MAX = 20'sd150000;

  // Resolved control settings handed to the datapath
  typedef struct packed {
    logic             ovr_active;
    lvl_t             ovr_level;
    logic             fixed_mode;
    lvl_t             fixed_level;
    trip_mc_t [3:0]   trip_mc;     // index 0 is the level 1 trip
  } cfg_t;

  function automatic logic [DutyW-1:0] duty_of(input lvl_t lvl);
    logic [DutyW-1:0] d;
    unique case (lvl)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd75;
      3'd2:    d = 8'd125;
      3'd3:    d = 8'd175;
      3'd4:    d = 8'd250;
      default: d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/fhc_cfg.sv
`timescale 1ns / 1ps
module fhc_cfg import fhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [1:0] mode_q;
  lvl_t       fixed_q;
  logic [7:0] trip1_q, trip2_q, trip3_q, trip4_q;
  logic [3:0] ovr_q;
  logic       custom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_AUTO;
      fixed_q <= LVL_SAFE;
      trip1_q <= 8'd50;
      trip2_q <= 8'd60;
      trip3_q <= 8'd68;
      trip4_q <= 8'd75;
      ovr_q   <= 4'hF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLICY_MODE:    mode_q  <= cfg_data_i[1:0];
        CFG_FIXED_LEVEL:    fixed_q <= cfg_data_i[LvlW-1:0];
        CFG_TRIP_ONE_C:     trip1_q <= cfg_data_i;
        CFG_TRIP_TWO_C:     trip2_q <= cfg_data_i;
        CFG_TRIP_THREE_C:   trip3_q <= cfg_data_i;
        CFG_TRIP_FOUR_C:    trip4_q <= cfg_data_i;
        CFG_OVERRIDE_LEVEL: ovr_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Custom trips count only when sane and strictly ascending
  assign custom = (mode_q == MODE_CUSTOM) && (trip1_q >= CUSTOM_MIN_C) &&
                  (trip4_q <= CUSTOM_MAX_C) && (trip1_q < trip2_q) &&
                  (trip2_q < trip3_q) && (trip3_q < trip4_q);

  always_comb begin
    cfg_o.ovr_active  = (ovr_q <= 4'(LVL_MAX));
    cfg_o.ovr_level   = ovr_q[LvlW-1:0];
    cfg_o.fixed_mode  = (mode_q == MODE_FIXED);
    cfg_o.fixed_level = (fixed_q > LVL_MAX) ? LVL_SAFE : fixed_q;
    if (custom) begin
      cfg_o.trip_mc[0] = TripW'(trip1_q) * TripW'(MILLI_PER_C);
      cfg_o.trip_mc[1] = TripW'(trip2_q) * TripW'(MILLI_PER_C);
      cfg_o.trip_mc[2] = TripW'(trip3_q) * TripW'(MILLI_PER_C);
      cfg_o.trip_mc[3] = TripW'(trip4_q) * TripW'(MILLI_PER_C);
    end else begin
      cfg_o.trip_mc[0] = DEF_TRIP_1;
      cfg_o.trip_mc[1] = DEF_TRIP_2;
      cfg_o.trip_mc[2] = DEF_TRIP_3;
      cfg_o.trip_mc[3] = DEF_TRIP_4;
    end
  end

endmodule

FILE: rtl/fhc_ctrl.sv
`timescale 1ns / 1ps
module fhc_ctrl import fhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                transport_ready_i,
  input  logic                temp_valid_i,
  input  logic [TempW-1:0]    temp_milli_c_i,
  input  logic                command_accepted_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                command_valid_o,
  output lvl_t                command_level_o,
  output lvl_t                level_now_o,
  output logic                level_known_o,
  output logic [DutyW-1:0]    duty_o
);

  logic             in_vld_q;
  logic             rdy_q, tval_q, acc_q;
  logic [TempW-1:0] temp_q;
  logic             out_vld_q;
  logic             cv_q, known_q;
  lvl_t             cl_q, now_q;
  logic [DutyW-1:0] duty_q;

  lvl_t             cur_q, cur_d;
  logic             kn_q, kn_d;

  logic             advance;
  logic             issue;
  lvl_t             cmd, target, loop_tgt;
  logic signed [CalcW-1:0] t_ext, t_sat, cur_trip, hyst_thr;
  logic [3:0]       ge;

  // Result stage frees up when empty or when its beat is taken
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rdy_q  <= transport_ready_i;
      tval_q <= temp_valid_i;
      temp_q <= temp_milli_c_i;
      acc_q  <= command_accepted_i;
    end
  end

  // Saturate and compare against the four trips
  always_comb begin
    t_ext = CalcW'(signed'(temp_q));
    if (t_ext < TEMP_MIN) begin
      t_sat = TEMP_MIN;
    end else if (t_ext > TEMP_MAX) begin
      t_sat = TEMP_MAX;
    end else begin
      t_sat = t_ext;
    end
    for (int i = 0; i < 4; i++) begin
      ge[i] = t_sat >= $signed({2'b00, cfg_i.trip_mc[i]});
    end
  end

  always_comb begin
    priority if (ge[3]) target = 3'd4;
    else if (ge[2])     target = 3'd3;
    else if (ge[1])     target = 3'd2;
    else if (ge[0])     target = 3'd1;
    else                target = 3'd0;
  end

  always_comb begin
    unique case (cur_q)
      3'd1:    cur_trip = $signed({2'b00, cfg_i.trip_mc[0]});
      3'd2:    cur_trip = $signed({2'b00, cfg_i.trip_mc[1]});
      3'd3:    cur_trip = $signed({2'b00, cfg_i.trip_mc[2]});
      default: cur_trip = $signed({2'b00, cfg_i.trip_mc[3]});
    endcase
    hyst_thr = cur_trip - HYST_MC;
  end

  // Step down one level only below the hysteresis band
  always_comb begin
    loop_tgt = target;
    if (kn_q && (target < cur_q)) begin
      loop_tgt = (t_sat >= hyst_thr) ? cur_q : cur_q - 3'd1;
    end
  end

  always_comb begin
    issue = 1'b0;
    cmd   = '0;
    if (rdy_q) begin
      priority if (cfg_i.ovr_active) begin
        issue = !kn_q || (cur_q != cfg_i.ovr_level);
        cmd   = cfg_i.ovr_level;
      end else if (cfg_i.fixed_mode) begin
        issue = !kn_q || (cur_q != cfg_i.fixed_level);
        cmd   = cfg_i.fixed_level;
      end else if (!tval_q) begin
        issue = !kn_q || (cur_q < LVL_SAFE);
        cmd   = LVL_SAFE;
      end else begin
        issue = !kn_q || (loop_tgt != cur_q);
        cmd   = loop_tgt;
      end
    end
    if (!issue) begin
      cmd = '0;
    end
  end

  always_comb begin
    cur_d = cur_q;
    kn_d  = kn_q;
    if (in_vld_q && advance && issue && acc_q) begin
      cur_d = cmd;
      kn_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      kn_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_q <= cur_d;
      kn_q  <= kn_d;
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      cv_q    <= issue;
      cl_q    <= cmd;
      now_q   <= kn_d ? cur_d : '0;
      known_q <= kn_d;
      duty_q  <= kn_d ? duty_of(cur_d) : '0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign command_valid_o = cv_q;
  assign command_level_o = cl_q;
  assign level_now_o     = now_q;
  assign level_known_o   = known_q;
  assign duty_o          = duty_q;

endmodule

FILE: rtl/fan_level_hysteresis_control_top.sv
`timescale 1ns / 1ps
// Fan level controller with thermal trips and hysteresis.
// An accepted beat passes an input then an output register; the level state feeds back
// through one register. Throughput: one beat per cycle unless the output stalls.
// Reset: async active low; clears the level state, the pipeline valids and sets
// the configuration registers to their defaults.
module fan_level_hysteresis_control_top import fhc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] transport_ready, [1] temp_valid, [20:2] temp_milli_c, [21] command_accepted
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] command_valid, [3:1] command_level, [6:4] level_now, [7] level_known,
  // [15:8] duty_out_of_255
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t             cfg;
  logic             cmd_valid, known;
  lvl_t             cmd_level, lvl_now;
  logic [DutyW-1:0] duty;

  fhc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  fhc_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .transport_ready_i  (s_axis_tdata[0]),
    .temp_valid_i       (s_axis_tdata[1]),
    .temp_milli_c_i     (s_axis_tdata[20:2]),
    .command_accepted_i (s_axis_tdata[21]),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .command_valid_o    (cmd_valid),
    .command_level_o    (cmd_level),
    .level_now_o        (lvl_now),
    .level_known_o      (known),
    .duty_o             (duty)
  );

  assign m_axis_tdata = {duty, known, lvl_now, cmd_level, cmd_valid};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

import fhc_pkg::*;

class fan_level_tracker;
  logic [1:0]  mode;
  lvl_t        fixed_lvl;
  logic [7:0]  trip_c [4];   // index 0 is the level 1 trip
  logic [3:0]  ovr;
  lvl_t        level;
  bit          known;
  logic [OutDataW-1:0] expected_reports [$];
  int unsigned ticks_noted;
  int unsigned commands_due;
  int unsigned reports_seen;
  int unsigned mismatches;

  function new();
    mode = MODE_AUTO;
    fixed_lvl = 3'd2;
    trip_c[0] = 8'd50;
    trip_c[1] = 8'd60;
    trip_c[2] = 8'd68;
    trip_c[3] = 8'd75;
    ovr = 4'hF;
    level = '0;
    known = 1'b0;
    ticks_noted = 0;
    commands_due = 0;
    reports_seen = 0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_POLICY_MODE:    mode = val[1:0];
      CFG_FIXED_LEVEL:    fixed_lvl = val[2:0];
      CFG_TRIP_ONE_C:     trip_c[0] = val;
      CFG_TRIP_TWO_C:     trip_c[1] = val;
      CFG_TRIP_THREE_C:   trip_c[2] = val;
      CFG_TRIP_FOUR_C:    trip_c[3] = val;
      CFG_OVERRIDE_LEVEL: ovr = val[3:0];
      default: ;
    endcase
  endfunction

  function int trip_mc(int lvl, bit custom);
    if (lvl > 4) lvl = 4;
    if (custom) return int'(trip_c[lvl-1]) * 1000;
    case (lvl)
      1:       return 50000;
      2:       return 60000;
      3:       return 67500;
      4:       return 75000;
      default: return 0;
    endcase
  endfunction

  function logic [DutyW-1:0] duty_for(lvl_t lvl);
    case (lvl)
      3'd1:    return 8'd75;
      3'd2:    return 8'd125;
      3'd3:    return 8'd175;
      3'd4:    return 8'd250;
      default: return 8'd0;
    endcase
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  // Advance the fan state by one accepted tick and queue the report it yields.
  function void note_tick(logic [InDataW-1:0] beat);
    logic link_up, reading_ok, ack;
    logic signed [TempW-1:0] raw;
    int t;
    bit issue, custom;
    lvl_t cmd, fl, target;
    logic [DutyW-1:0] duty;
    link_up = beat[0];
    reading_ok = beat[1];
    raw = beat[20:2];
    ack = beat[21];
    issue = 1'b0;
    custom = 1'b0;
    cmd = '0;
    target = '0;
    ticks_noted++;
    if (link_up) begin
      if (ovr <= 4'd4) begin
        if (!known || level != ovr[2:0]) begin
          issue = 1'b1;
          cmd = ovr[2:0];
        end
      end else if (mode == MODE_FIXED) begin
        fl = (fixed_lvl > LVL_MAX) ? LVL_SAFE : fixed_lvl;
        if (!known || level != fl) begin
          issue = 1'b1;
          cmd = fl;
        end
      end else if (!reading_ok) begin
        if (!known || level < LVL_SAFE) begin
          issue = 1'b1;
          cmd = LVL_SAFE;
        end
      end else begin
        t = int'(raw);
        if (t < -50000) t = -50000;
        if (t > 150000) t = 150000;
        custom = (mode == MODE_CUSTOM) && trip_c[0] >= 8'd30 && trip_c[3] <= 8'd90 &&
                 trip_c[0] < trip_c[1] && trip_c[1] < trip_c[2] && trip_c[2] < trip_c[3];
        for (int i = 4; i >= 1; i--) begin
          if (t >= trip_mc(i, custom)) begin
            target = lvl_t'(i);
            break;
          end
        end
        // hold inside the band below the current trip, else step down one level
        if (known && target < level) begin
          if (t >= trip_mc(int'(level), custom) - 5000) target = level;
          else target = level - 3'd1;
        end
        if (!known || target != level) begin
          issue = 1'b1;
          cmd = target;
        end
      end
      if (issue && ack) begin
        level = cmd;
        known = 1'b1;
      end
    end
    if (issue) commands_due++;
    duty = known ? duty_for(level) : 8'd0;
    expected_reports.push_back({duty, known, known ? level : 3'd0, cmd, issue});
  endfunction

  function void check_report(logic [OutDataW-1:0] got);
    logic [OutDataW-1:0] want;
    string bad;
    reports_seen++;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = expected_reports.pop_front();
    bad = "";
    if (got[0] !== want[0]) bad = {bad, " command_valid"};
    if (got[3:1] !== want[3:1]) bad = {bad, " command_level"};
    if (got[6:4] !== want[6:4]) bad = {bad, " level_now"};
    if (got[7] !== want[7]) bad = {bad, " level_known"};
    if (got[15:8] !== want[15:8]) bad = {bad, " duty"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on%s: expected cmd=%0d/%0d now=%0d known=%0d duty=%0d, got cmd=%0d/%0d now=%0d known=%0d duty=%0d",
                 bad, want[0], want[3:1], want[6:4], want[7], want[15:8],
                 got[0], got[3:1], got[6:4], got[7], got[15:8]);
    end
  endfunction
endclass

module testbench;
  localparam logic [1:0] MODE_UNDEFINED = 2'd3;
  localparam logic [3:0] OVR_NONE       = 4'hF;
  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned TICKS_PER_PHASE = 90;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  fan_level_tracker tracker;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 52;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;

  fan_level_hysteresis_control_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check the result beat that lands on this edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [InDataW-1:0] pack_tick(bit rdy, bit ok, int temp, bit ack);
    return {2'b00, ack, temp[TempW-1:0], ok, rdy};
  endfunction

  task automatic push_tick(input logic [InDataW-1:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= beat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_tick(beat);
  endtask

  // Hold the sender until every queued report has come back.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
  endtask

  task automatic set_policy(input logic [1:0] mode, input logic [2:0] fixed,
                            input logic [7:0] t1, input logic [7:0] t2,
                            input logic [7:0] t3, input logic [7:0] t4,
                            input logic [3:0] ovr);
    hold_until_drained();
    write_reg(CFG_POLICY_MODE, {6'd0, mode});
    write_reg(CFG_FIXED_LEVEL, {5'd0, fixed});
    write_reg(CFG_TRIP_ONE_C, t1);
    write_reg(CFG_TRIP_TWO_C, t2);
    write_reg(CFG_TRIP_THREE_C, t3);
    write_reg(CFG_TRIP_FOUR_C, t4);
    write_reg(CFG_OVERRIDE_LEVEL, {4'd0, ovr});
    cfg_we_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    settings_used++;
  endtask

  initial begin
    logic [7:0] t1, t2, t3, t4;
    logic [3:0] ovr;
    logic signed [TempW-1:0] raw;
    int walk;
    bit failed;
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: automatic default curve, no override
    push_tick(pack_tick(0, 1, 150000, 1));   // link down, ack ignored
    push_tick(pack_tick(1, 0, 0, 0));        // bad reading, unknown level, no ack
    push_tick(pack_tick(1, 1, 150000, 0));
    push_tick(pack_tick(1, 0, 0, 1));        // safe level acked
    push_tick(pack_tick(1, 0, 0, 1));
    push_tick(pack_tick(1, 1, 150000, 1));
    push_tick(pack_tick(1, 1, 262143, 1));   // saturates high
    push_tick(pack_tick(1, 1, 70000, 1));    // bottom edge of the band
    push_tick(pack_tick(1, 1, 69999, 0));
    push_tick(pack_tick(1, 1, 69999, 1));
    push_tick(pack_tick(1, 1, -262144, 1));  // saturates low
    push_tick(pack_tick(1, 1, -50000, 1));
    push_tick(pack_tick(1, 1, -50001, 1));
    push_tick(pack_tick(1, 1, 49999, 1));
    push_tick(pack_tick(1, 0, 0, 1));
    push_tick(pack_tick(1, 1, 67500, 1));
    push_tick(pack_tick(0, 0, 0, 0));

    set_policy(MODE_FIXED, 3'd7, 8'd50, 8'd60, 8'd68, 8'd75, 4'd4);
    push_tick(pack_tick(1, 1, 0, 1));
    push_tick(pack_tick(1, 0, 0, 1));
    set_policy(MODE_FIXED, 3'd7, 8'd50, 8'd60, 8'd68, 8'd75, 4'h8);
    push_tick(pack_tick(1, 1, 150000, 1));
    push_tick(pack_tick(1, 1, 150000, 1));
    set_policy(MODE_CUSTOM, 3'd0, 8'd30, 8'd40, 8'd60, 8'd90, OVR_NONE);
    push_tick(pack_tick(1, 1, 90000, 1));
    push_tick(pack_tick(1, 1, 84999, 1));
    push_tick(pack_tick(1, 1, 30000, 1));
    set_policy(MODE_UNDEFINED, 3'd4, 8'd30, 8'd40, 8'd60, 8'd90, OVR_NONE);
    push_tick(pack_tick(1, 1, 55000, 1));

    walk = 55000;
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 38;
        recv_idle_pct = 52;
      end else if (p < 8) begin
        send_idle_pct = 52;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: {t1, t2, t3, t4} = {8'd30, 8'd31, 8'd32, 8'd33};
        1: {t1, t2, t3, t4} = {8'd87, 8'd88, 8'd89, 8'd90};
        2: {t1, t2, t3, t4} = {8'd0, 8'd0, 8'd255, 8'd255};
        3: {t1, t2, t3, t4} = {8'd255, 8'd128, 8'd64, 8'd0};
        default: begin
          if ($urandom_range(1) == 0) begin
            t1 = 8'($urandom_range(60, 30));
            t2 = t1 + 8'($urandom_range(10, 1));
            t3 = t2 + 8'($urandom_range(10, 1));
            t4 = t3 + 8'($urandom_range(90 - int'(t3), 1));
          end else begin
            t1 = 8'($urandom);
            t2 = 8'($urandom);
            t3 = 8'($urandom);
            t4 = 8'($urandom);
          end
        end
      endcase
      ovr = (p % 3 == 2) ? 4'($urandom) : OVR_NONE;
      set_policy(2'(p % 4), 3'($urandom), t1, t2, t3, t4, ovr);
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 10) begin
          raw = TempW'($urandom);
          push_tick(pack_tick($urandom_range(99) < 92, $urandom_range(99) < 93,
                              int'(raw), $urandom_range(99) < 80));
        end else begin
          // drift around the trips so the band and step-down paths get work
          if ($urandom_range(99) < 5) walk = int'($urandom_range(200000)) - 50000;
          else walk = walk + int'($urandom_range(6000)) - 3000;
          if (walk < -60000) walk = -60000;
          if (walk > 160000) walk = 160000;
          push_tick(pack_tick($urandom_range(99) < 92, $urandom_range(99) < 93,
                              walk, $urandom_range(99) < 80));
        end
      end
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    failed = (tracker.mismatches != 0) || (tracker.pending() != 0);
    $display("%0d ticks over %0d register settings, %0d level commands, %0d result beats checked",
             tracker.ticks_noted, settings_used, tracker.commands_due, tracker.reports_seen);
    $display("covered override, fixed, automatic, custom and undefined modes under stalls, %0d mismatches",
             tracker.mismatches);
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/fhc_pkg.sv
rtl/fhc_cfg.sv
rtl/fhc_ctrl.sv
rtl/fan_level_hysteresis_control_top.sv
sim/testbench.sv
